>>> rtl/modexp_pkg.sv
// Shared widths, constants and state encoding for the modular exponentiation core.
`default_nettype none
package modexp_pkg;

	// Field widths
	localparam int MOD_W     = 31;  // modulus, base and result
	localparam int EXP_IN_W  = 32;  // exponent field as carried on the stream
	localparam int IN_DATA_W = 64;  // base + exponent, padded to bytes
	localparam int OUT_DATA_W = 32; // result, padded to bytes

	// Defaults
	localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(1000000007);
	localparam int EXP_BITS_DEF = 32;

	// One modular multiply walks one multiplier bit per cycle
	localparam int MUL_STEPS = MOD_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQUARE,
		ST_MULT,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

>>> rtl/modular_exponentiation_core.sv
// Modular exponentiation core: left-to-right square-and-multiply over a bit-serial modmul.
//
// Each input item carries a base and an exponent and yields one item holding
// base^exponent mod modulus; an exponent whose low EXP_BITS bits are zero yields
// exactly 1, and a zero modulus yields 0 for any other exponent. One item is
// worked on at a time. All arithmetic runs through a single bit-serial modular
// multiplier that consumes one multiplier bit per cycle. An item is processed in
// order: it is accepted, the base is reduced, each scanned exponent bit gets one
// squaring, each set bit gets one extra multiply by the base, and the result is
// handed off to the output register once that register is free or being read.
// A finished result waits in the output register, and the next item may be
// accepted meanwhile. The modulus register is written through cfg_we/cfg_wdata;
// the user must write it only while the core is idle, as the core does not enforce it.
`default_nettype none
module modular_exponentiation_core #(
	parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration: modulus
	input  wire logic                               cfg_we,
	input  wire logic [modexp_pkg::MOD_W-1:0]       cfg_wdata,
	// input items
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [modexp_pkg::IN_DATA_W-1:0]   s_tdata,  // [30:0] base_value, [62:31] exponent
	// result items
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [modexp_pkg::OUT_DATA_W-1:0]       m_tdata   // [30:0] power_result
);

	localparam int MW = modexp_pkg::MOD_W;
	localparam int EW = $clog2(EXP_BITS + 1);
	localparam int CW = modexp_pkg::MUL_CNT_W;

	modexp_pkg::state_t state_q, state_d;

	logic [MW-1:0]       m_q;        // modulus
	logic [MW-1:0]       base_q;     // base reduced mod m
	logic [MW-1:0]       acc_q;      // running power / final result
	logic [MW-1:0]       r_q;        // multiplier partial result
	logic [MW-1:0]       x_q;        // multiplicand
	logic [MW-1:0]       y_q;        // multiplier, shifted out MSB first
	logic [CW-1:0]       dcnt_q;     // multiplier bits left minus one
	logic [EXP_BITS-1:0] exp_q;      // exponent, shifted out MSB first
	logic [EW-1:0]       ecnt_q;     // exponent bits left
	logic [MW-1:0]       out_q;
	logic                out_valid_q;

	// Input field split
	logic [MW-1:0]       in_base;
	logic [EXP_BITS-1:0] in_exp;
	logic                in_accept;
	logic                in_exp_zero;
	logic                in_mod_zero;

	assign in_base     = s_tdata[MW-1:0];
	assign in_exp      = EXP_BITS'(s_tdata[MW +: modexp_pkg::EXP_IN_W]);
	assign in_accept   = s_tvalid && s_tready;
	assign in_exp_zero = (in_exp == '0);
	assign in_mod_zero = (m_q == '0);

	// One step of the interleaved modular multiply: r = (2r + bit*x) mod m
	logic [MW:0]   dbl, red1, sum, red2;
	logic [MW-1:0] r_next;
	logic          mul_last;
	logic          exp_bit;
	logic          exp_last;

	always_comb begin
		dbl    = {r_q, 1'b0};
		red1   = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		sum    = red1 + (y_q[MW-1] ? {1'b0, x_q} : '0);
		red2   = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
		r_next = red2[MW-1:0];
	end

	assign mul_last = (dcnt_q == '0);
	assign exp_bit  = exp_q[EXP_BITS-1];
	assign exp_last = (ecnt_q == EW'(1));

	// Handshake outputs
	assign s_tready = (state_q == modexp_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(modexp_pkg::OUT_DATA_W - MW){1'b0}}, out_q};

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= modexp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			modexp_pkg::ST_IDLE: begin
				if (in_accept) begin
					state_d = (in_exp_zero || in_mod_zero) ? modexp_pkg::ST_DONE
					                                       : modexp_pkg::ST_REDUCE;
				end
			end
			modexp_pkg::ST_REDUCE: begin
				if (mul_last) begin
					state_d = modexp_pkg::ST_SQUARE;
				end
			end
			modexp_pkg::ST_SQUARE: begin
				if (mul_last) begin
					if (exp_bit) begin
						state_d = modexp_pkg::ST_MULT;
					end else if (exp_last) begin
						state_d = modexp_pkg::ST_DONE;
					end else begin
						state_d = modexp_pkg::ST_SQUARE;
					end
				end
			end
			modexp_pkg::ST_MULT: begin
				if (mul_last) begin
					state_d = exp_last ? modexp_pkg::ST_DONE : modexp_pkg::ST_SQUARE;
				end
			end
			modexp_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = modexp_pkg::ST_IDLE;
				end
			end
			default: state_d = modexp_pkg::ST_IDLE;
		endcase
	end

	// Modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= modexp_pkg::MODULUS_RESET;
		end else if (cfg_we) begin
			m_q <= cfg_wdata;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == modexp_pkg::ST_DONE && (!out_valid_q || m_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == modexp_pkg::ST_DONE && (!out_valid_q || m_tready)) begin
			out_q <= acc_q;
		end
	end

	// Datapath: multiplier operands, exponent scan, running value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			ecnt_q <= '0;
		end else begin
			case (state_q)
				modexp_pkg::ST_IDLE: begin
					if (in_accept) begin
						dcnt_q <= CW'(modexp_pkg::MUL_STEPS - 1);
						ecnt_q <= EW'(EXP_BITS);
					end
				end
				modexp_pkg::ST_REDUCE, modexp_pkg::ST_SQUARE, modexp_pkg::ST_MULT: begin
					if (mul_last) begin
						dcnt_q <= CW'(modexp_pkg::MUL_STEPS - 1);
						// a bit is finished after its square when the bit is clear
						if (state_q == modexp_pkg::ST_MULT ||
						    (state_q == modexp_pkg::ST_SQUARE && !exp_bit)) begin
							ecnt_q <= ecnt_q - EW'(1);
						end
					end else begin
						dcnt_q <= dcnt_q - CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			modexp_pkg::ST_IDLE: begin
				if (in_accept) begin
					// reduce the base first: base * 1 mod m
					r_q   <= '0;
					x_q   <= MW'(1);
					y_q   <= in_base;
					exp_q <= in_exp;
					acc_q <= in_exp_zero ? MW'(1) : '0;
				end
			end
			modexp_pkg::ST_REDUCE: begin
				if (mul_last) begin
					base_q <= r_next;
					// first square of the running value 1
					acc_q  <= MW'(1);
					r_q    <= '0;
					x_q    <= MW'(1);
					y_q    <= MW'(1);
				end else begin
					r_q <= r_next;
					y_q <= y_q << 1;
				end
			end
			modexp_pkg::ST_SQUARE: begin
				if (mul_last) begin
					acc_q <= r_next;
					r_q   <= '0;
					y_q   <= r_next;
					if (exp_bit) begin
						x_q <= base_q;
					end else begin
						x_q   <= r_next;
						exp_q <= exp_q << 1;
					end
				end else begin
					r_q <= r_next;
					y_q <= y_q << 1;
				end
			end
			modexp_pkg::ST_MULT: begin
				if (mul_last) begin
					acc_q <= r_next;
					r_q   <= '0;
					x_q   <= r_next;
					y_q   <= r_next;
					exp_q <= exp_q << 1;
				end else begin
					r_q <= r_next;
					y_q <= y_q << 1;
				end
			end
			default: ;
		endcase
	end

	// Checks
	a_zero_exp_gives_one: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_exp_zero) |=> (state_q == modexp_pkg::ST_DONE && acc_q == MW'(1)))
		else $error("zero exponent did not produce one");

	a_zero_mod_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !in_exp_zero && in_mod_zero) |=>
		(state_q == modexp_pkg::ST_DONE && acc_q == '0))
		else $error("zero modulus did not produce zero");

	a_set_bit_multiplies: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == modexp_pkg::ST_SQUARE && mul_last && exp_bit) |=>
		(state_q == modexp_pkg::ST_MULT && x_q == base_q))
		else $error("set exponent bit skipped the base multiply");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == modexp_pkg::ST_DONE))
		else $error("result offered outside the hand-off state");

endmodule
`default_nettype wire
